/* sv/sml_pkg.sv */
// Shared types, constants and helper functions for the sector minimum altitude lookup.
// Has no dependencies; every other file imports it but sml_delay.
package sml_pkg;

	localparam int XW  = 34;  // rotation datapath width, Q30 values
	localparam int ZW  = 25;  // rotation angle width, Q16 degrees
	localparam int VXW = 36;  // vectoring datapath width
	localparam int VZW = 26;  // vectoring angle width
	localparam int SLOTS = 4; // sector words held in configuration

	localparam int Q16_FULL = 23592960;
	localparam int Q16_HALF = 11796480;
	localparam int CORDIC_GAIN_Q30 = 652032874;

	typedef struct packed {
		logic                 flip;
		logic signed [ZW-1:0] z;
	} sml_angle_t;

	// Arctangent of 2^-i in Q16 degrees.
	function automatic logic [21:0] atan_q16(input int i);
		logic [21:0] r;
		unique case (i)
			0: r = 22'd2949120;
			1: r = 22'd1740967;
			2: r = 22'd919879;
			3: r = 22'd466945;
			4: r = 22'd234379;
			5: r = 22'd117304;
			6: r = 22'd58666;
			7: r = 22'd29335;
			8: r = 22'd14668;
			9: r = 22'd7334;
			10: r = 22'd3667;
			11: r = 22'd1833;
			12: r = 22'd917;
			13: r = 22'd458;
			14: r = 22'd229;
			15: r = 22'd115;
			16: r = 22'd57;
			17: r = 22'd29;
			18: r = 22'd14;
			19: r = 22'd7;
			20: r = 22'd4;
			21: r = 22'd2;
			22: r = 22'd1;
			default: r = 22'd0;
		endcase
		return r;
	endfunction

	// Reduce an angle to (-180,180] degrees, then fold it into [-90,90].
	function automatic sml_angle_t reduce_fold(input logic signed [26:0] a);
		logic signed [26:0] t;
		sml_angle_t r;
		t = a;
		if (t >= 27'sd23592960) begin
			t = t - 27'sd23592960;
		end else if (t <= -27'sd23592960) begin
			t = t + 27'sd23592960;
		end
		if (t > 27'sd11796480) begin
			t = t - 27'sd23592960;
		end else if (t <= -27'sd11796480) begin
			t = t + 27'sd23592960;
		end
		r.flip = 1'b0;
		if (t > 27'sd5898240) begin
			t = t - 27'sd11796480;
			r.flip = 1'b1;
		end else if (t < -27'sd5898240) begin
			t = t + 27'sd11796480;
			r.flip = 1'b1;
		end
		r.z = t[ZW-1:0];
		return r;
	endfunction

	function automatic logic [31:0] mag32(input logic signed [35:0] v);
		logic signed [35:0] n;
		n = -v;
		return v[35] ? n[31:0] : v[31:0];
	endfunction

	// Joins two partial products of a 32 by 32 bit multiplication.
	function automatic logic [63:0] join_pp(input logic [47:0] lo, input logic [47:0] hi);
		return ({16'd0, hi} << 16) + {16'd0, lo};
	endfunction

	// Q30 product rounded half up in magnitude, sign applied afterwards.
	function automatic logic signed [34:0] q30_round(input logic [63:0] p, input logic neg);
		logic [63:0] s;
		logic signed [34:0] r;
		s = (p + 64'd536870912) >> 30;
		r = $signed(s[34:0]);
		return neg ? -r : r;
	endfunction

endpackage

/* sv/sml_rot_cell.sv */
// One rotation-mode CORDIC cell: a single micro-rotation, registered.
// Depends on sml_pkg for widths and the arctangent table.
module sml_rot_cell import sml_pkg::*; #(
	parameter int SHIFT = 0
) (
	input  logic                 clk,
	input  logic signed [XW-1:0] x_in,
	input  logic signed [XW-1:0] y_in,
	input  logic signed [ZW-1:0] z_in,
	output logic signed [XW-1:0] x_out,
	output logic signed [XW-1:0] y_out,
	output logic signed [ZW-1:0] z_out
);

	localparam logic signed [ZW-1:0] STEP = $signed({3'b000, atan_q16(SHIFT)});

	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;

	always_ff @(posedge clk) begin
		if (z_in >= 0) begin
			x_q <= x_in - (y_in >>> SHIFT);
			y_q <= y_in + (x_in >>> SHIFT);
			z_q <= z_in - STEP;
		end else begin
			x_q <= x_in + (y_in >>> SHIFT);
			y_q <= y_in - (x_in >>> SHIFT);
			z_q <= z_in + STEP;
		end
	end

	assign x_out = x_q;
	assign y_out = y_q;
	assign z_out = z_q;

endmodule

/* sv/sml_vec_cell.sv */
// One vectoring-mode CORDIC cell: drives y toward zero and sums the angle, registered.
// Depends on sml_pkg for widths and the arctangent table.
module sml_vec_cell import sml_pkg::*; #(
	parameter int SHIFT = 0
) (
	input  logic                  clk,
	input  logic signed [VXW-1:0] x_in,
	input  logic signed [VXW-1:0] y_in,
	input  logic signed [VZW-1:0] z_in,
	output logic signed [VXW-1:0] x_out,
	output logic signed [VXW-1:0] y_out,
	output logic signed [VZW-1:0] z_out
);

	localparam logic signed [VZW-1:0] STEP = $signed({4'b0000, atan_q16(SHIFT)});

	logic signed [VXW-1:0] x_q, y_q;
	logic signed [VZW-1:0] z_q;

	always_ff @(posedge clk) begin
		if (y_in >= 0) begin
			x_q <= x_in + (y_in >>> SHIFT);
			y_q <= y_in - (x_in >>> SHIFT);
			z_q <= z_in + STEP;
		end else begin
			x_q <= x_in - (y_in >>> SHIFT);
			y_q <= y_in + (x_in >>> SHIFT);
			z_q <= z_in - STEP;
		end
	end

	assign x_out = x_q;
	assign y_out = y_q;
	assign z_out = z_q;

endmodule

/* sv/sml_delay.sv */
// Shift line that carries an item's side data alongside a CORDIC chain.
// Depends on nothing but the clock and reset.
module sml_delay #(
	parameter int W     = 8,
	parameter int DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] line_q [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				line_q[i] <= '0;
			end
		end else begin
			line_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign q = line_q[DEPTH-1];

endmodule

/* sv/sector_minimum_altitude_lookup_top.sv */
// Top level of the sector minimum altitude lookup: configuration registers and the pipeline.
// Depends on sml_pkg, sml_rot_cell, sml_vec_cell and sml_delay.
//
// Channel  Direction  Handshake           Payload
// query    in         start, busy         aircraft_latitude, aircraft_longitude,
//                                         magnetic_variation
// result   out        done (strobe)       minimum_altitude_ft
// config   in         cfg_we              cfg_index, cfg_wdata
//
// The block takes one item in every clock cycle; busy stays low. Each item gives exactly
// one result, after it passes the two CORDIC chains (sine and cosine, then the bearing
// angle) and the multiplier stages between them. Results leave in order and are shown
// with done for a single cycle; the receiver cannot stall them. Reset clears the
// configuration and all valid flags.
module sector_minimum_altitude_lookup_top import sml_pkg::*; #(
	parameter int MAX_SECTORS   = 4,
	parameter int CORDIC_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [23:0] aircraft_latitude,
	input  logic signed [24:0] aircraft_longitude,
	input  logic signed [24:0] magnetic_variation,
	output logic               done,
	output logic [16:0]        minimum_altitude_ft,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [26:0]        cfg_wdata
);

	localparam logic [2:0] REG_CENTRE_LAT = 3'd0;
	localparam logic [2:0] REG_CENTRE_LON = 3'd1;
	localparam logic [2:0] REG_MAGNETIC   = 3'd2;
	localparam logic [2:0] REG_COUNT      = 3'd3;
	localparam logic [2:0] REG_WORD_0     = 3'd4;
	localparam logic [2:0] REG_WORD_1     = 3'd5;
	localparam logic [2:0] REG_WORD_2     = 3'd6;
	localparam logic [2:0] REG_WORD_3     = 3'd7;

	// The block never holds off a query.
	assign busy = 1'b0;

	// Configuration registers.
	logic signed [23:0] centre_latitude_q;
	logic signed [24:0] centre_longitude_q;
	logic               magnetic_reference_q;
	logic [2:0]         sector_count_q;
	logic [26:0]        sector_word_q [SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_latitude_q    <= '0;
			centre_longitude_q   <= '0;
			magnetic_reference_q <= 1'b0;
			sector_count_q       <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				sector_word_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CENTRE_LAT: centre_latitude_q    <= cfg_wdata[23:0];
				REG_CENTRE_LON: centre_longitude_q   <= cfg_wdata[24:0];
				REG_MAGNETIC:   magnetic_reference_q <= cfg_wdata[0];
				REG_COUNT:      sector_count_q       <= cfg_wdata[2:0];
				REG_WORD_0,
				REG_WORD_1,
				REG_WORD_2,
				REG_WORD_3:     sector_word_q[cfg_index[1:0]] <= cfg_wdata;
			endcase
		end
	end

	// Valid flags of the stages outside the CORDIC chains.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, done_q;

	// Stage 1 registers the query as it is taken.
	logic signed [23:0] la2_s1;
	logic signed [24:0] lo2_s1, mv_s1;

	always_ff @(posedge clk) begin
		la2_s1 <= aircraft_latitude;
		lo2_s1 <= aircraft_longitude;
		mv_s1  <= magnetic_variation;
	end

	// Stage 2 forms the four CORDIC angles (mean latitude, centre latitude, aircraft
	// latitude, longitude difference) and the latitude distance in Q16 nautical miles.
	logic signed [24:0] lat_sum, lat_mean, lat_diff;
	logic signed [25:0] lon_diff;
	logic [24:0]        lat_mag;
	logic [25:0]        lon_mag;

	assign lat_sum  = 25'(centre_latitude_q) + 25'(la2_s1);
	assign lat_mean = (lat_sum + $signed({24'd0, lat_sum[24]})) >>> 1;
	assign lat_diff = 25'(la2_s1) - 25'(centre_latitude_q);
	assign lon_diff = 26'(lo2_s1) - 26'(centre_longitude_q);
	assign lat_mag  = lat_diff[24] ? 25'(-lat_diff) : 25'(lat_diff);
	assign lon_mag  = lon_diff[25] ? 26'(-lon_diff) : 26'(lon_diff);

	sml_angle_t         ang_s2 [4];
	logic [30:0]        dlat_s2;
	logic [31:0]        dlom60_s2;
	logic signed [24:0] mv_s2;

	always_ff @(posedge clk) begin
		ang_s2[0] <= reduce_fold(27'(lat_mean));
		ang_s2[1] <= reduce_fold(27'(centre_latitude_q));
		ang_s2[2] <= reduce_fold(27'(la2_s1));
		ang_s2[3] <= reduce_fold(27'(lon_diff));
		dlat_s2   <= 31'(lat_mag) * 31'd60;
		dlom60_s2 <= 32'(lon_mag) * 32'd60;
		mv_s2     <= mv_s1;
	end

	// Four rotation chains give the sines and cosines.
	typedef struct packed {
		logic               v;
		logic [3:0]         flip;
		logic [30:0]        dlat;
		logic [31:0]        dlom60;
		logic signed [24:0] mv;
	} rot_side_t;

	rot_side_t rot_side_in, rot_side_out;
	logic signed [XW-1:0] rot_x [4][CORDIC_STAGES+1];
	logic signed [XW-1:0] rot_y [4][CORDIC_STAGES+1];
	logic signed [ZW-1:0] rot_z [4][CORDIC_STAGES+1];

	assign rot_side_in = '{v: v_s2,
		flip: {ang_s2[3].flip, ang_s2[2].flip, ang_s2[1].flip, ang_s2[0].flip},
		dlat: dlat_s2, dlom60: dlom60_s2, mv: mv_s2};

	sml_delay #(.W($bits(rot_side_t)), .DEPTH(CORDIC_STAGES)) u_rot_side (
		.clk    (clk),
		.arst_n (arst_n),
		.d      (rot_side_in),
		.q      (rot_side_out)
	);

	for (genvar j = 0; j < 4; j++) begin : g_rot
		assign rot_x[j][0] = XW'(CORDIC_GAIN_Q30);
		assign rot_y[j][0] = '0;
		assign rot_z[j][0] = ang_s2[j].z;
		for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
			sml_rot_cell #(.SHIFT(k)) u_cell (
				.clk   (clk),
				.x_in  (rot_x[j][k]),
				.y_in  (rot_y[j][k]),
				.z_in  (rot_z[j][k]),
				.x_out (rot_x[j][k+1]),
				.y_out (rot_y[j][k+1]),
				.z_out (rot_z[j][k+1])
			);
		end
	end

	// Stage 3 applies the fold correction and splits values into magnitude and sign.
	logic signed [XW-1:0] cos_v [4];
	logic signed [XW-1:0] sin_v [4];

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			cos_v[j] = rot_side_out.flip[j] ? -rot_x[j][CORDIC_STAGES] : rot_x[j][CORDIC_STAGES];
			sin_v[j] = rot_side_out.flip[j] ? -rot_y[j][CORDIC_STAGES] : rot_y[j][CORDIC_STAGES];
		end
	end

	logic [31:0]          mcm_s3, ms1_s3, mc1_s3, ms2_s3, mc2_s3, msd_s3;
	logic                 ns1_s3, nc1_s3, ns2_s3, nc2_s3, nsd_s3;
	logic signed [XW-1:0] cd_s3;
	logic [30:0]          dlat_s3;
	logic [31:0]          dlom60_s3;
	logic signed [24:0]   mv_s3;

	always_ff @(posedge clk) begin
		mcm_s3    <= mag32(36'(cos_v[0]));
		ms1_s3    <= mag32(36'(sin_v[1]));
		mc1_s3    <= mag32(36'(cos_v[1]));
		ms2_s3    <= mag32(36'(sin_v[2]));
		mc2_s3    <= mag32(36'(cos_v[2]));
		msd_s3    <= mag32(36'(sin_v[3]));
		ns1_s3    <= sin_v[1][XW-1];
		nc1_s3    <= cos_v[1][XW-1];
		ns2_s3    <= sin_v[2][XW-1];
		nc2_s3    <= cos_v[2][XW-1];
		nsd_s3    <= sin_v[3][XW-1];
		cd_s3     <= cos_v[3];
		dlat_s3   <= rot_side_out.dlat;
		dlom60_s3 <= rot_side_out.dlom60;
		mv_s3     <= rot_side_out.mv;
	end

	// Stage 4 forms the partial products, each multiplier at most 32 by 16 bits.
	logic [47:0]          dlon_lo_s4, dlon_hi_s4, dlat_lo_s4, dlat_hi_s4;
	logic [47:0]          by_lo_s4, by_hi_s4, t1_lo_s4, t1_hi_s4, t2_lo_s4, t2_hi_s4;
	logic                 by_neg_s4, t1_neg_s4, t2_neg_s4;
	logic signed [XW-1:0] cd_s4;
	logic signed [24:0]   mv_s4;

	always_ff @(posedge clk) begin
		dlon_lo_s4 <= 48'(dlom60_s3) * 48'(mcm_s3[15:0]);
		dlon_hi_s4 <= 48'(dlom60_s3) * 48'(mcm_s3[31:16]);
		dlat_lo_s4 <= 48'(dlat_s3) * 48'(dlat_s3[15:0]);
		dlat_hi_s4 <= 48'(dlat_s3) * 48'(dlat_s3[30:16]);
		by_lo_s4   <= 48'(msd_s3) * 48'(mc2_s3[15:0]);
		by_hi_s4   <= 48'(msd_s3) * 48'(mc2_s3[31:16]);
		t1_lo_s4   <= 48'(mc1_s3) * 48'(ms2_s3[15:0]);
		t1_hi_s4   <= 48'(mc1_s3) * 48'(ms2_s3[31:16]);
		t2_lo_s4   <= 48'(ms1_s3) * 48'(mc2_s3[15:0]);
		t2_hi_s4   <= 48'(ms1_s3) * 48'(mc2_s3[31:16]);
		by_neg_s4  <= nsd_s3 ^ nc2_s3;
		t1_neg_s4  <= nc1_s3 ^ ns2_s3;
		t2_neg_s4  <= ns1_s3 ^ nc2_s3;
		cd_s4      <= cd_s3;
		mv_s4      <= mv_s3;
	end

	// Stage 5 joins the partial products and rounds the Q30 results.
	logic [63:0]          dlon_full, dlat2_s5;
	logic [31:0]          dlon_s5;
	logic signed [34:0]   by_s5, t1_s5, t2_s5;
	logic signed [XW-1:0] cd_s5;
	logic signed [24:0]   mv_s5;

	assign dlon_full = join_pp(dlon_lo_s4, dlon_hi_s4) + 64'd536870912;

	always_ff @(posedge clk) begin
		dlon_s5  <= dlon_full[61:30];
		dlat2_s5 <= join_pp(dlat_lo_s4, dlat_hi_s4);
		by_s5    <= q30_round(join_pp(by_lo_s4, by_hi_s4), by_neg_s4);
		t1_s5    <= q30_round(join_pp(t1_lo_s4, t1_hi_s4), t1_neg_s4);
		t2_s5    <= q30_round(join_pp(t2_lo_s4, t2_hi_s4), t2_neg_s4);
		cd_s5    <= cd_s4;
		mv_s5    <= mv_s4;
	end

	// Stage 6: second round of partial products (east distance squared, third product).
	logic [31:0]        t2_mag, cd_mag;
	logic [47:0]        dl2_lo_s6, dl2_hi_s6, t3_lo_s6, t3_hi_s6;
	logic               t3_neg_s6;
	logic [63:0]        dlat2_s6;
	logic signed [34:0] by_s6, t1_s6;
	logic signed [24:0] mv_s6;

	assign t2_mag = mag32(36'(t2_s5));
	assign cd_mag = mag32(36'(cd_s5));

	always_ff @(posedge clk) begin
		dl2_lo_s6 <= 48'(dlon_s5) * 48'(dlon_s5[15:0]);
		dl2_hi_s6 <= 48'(dlon_s5) * 48'(dlon_s5[31:16]);
		t3_lo_s6  <= 48'(t2_mag) * 48'(cd_mag[15:0]);
		t3_hi_s6  <= 48'(t2_mag) * 48'(cd_mag[31:16]);
		t3_neg_s6 <= t2_s5[34] ^ cd_s5[XW-1];
		dlat2_s6  <= dlat2_s5;
		by_s6     <= by_s5;
		t1_s6     <= t1_s5;
		mv_s6     <= mv_s5;
	end

	// Stage 7 completes the bearing vector and the squared distance.
	logic signed [34:0] bx_s7, by_s7;
	logic [63:0]        d2_s7;
	logic signed [24:0] mv_s7;

	always_ff @(posedge clk) begin
		bx_s7 <= t1_s6 - q30_round(join_pp(t3_lo_s6, t3_hi_s6), t3_neg_s6);
		by_s7 <= by_s6;
		d2_s7 <= dlat2_s6 + join_pp(dl2_lo_s6, dl2_hi_s6);
		mv_s7 <= mv_s6;
	end

	// Stage 8 prepares the vectoring chain: a half turn when x is negative.
	logic signed [VXW-1:0] vx_s8, vy_s8;
	logic signed [VZW-1:0] vz_s8;
	logic                  zero_s8;
	logic [63:0]           d2_s8;
	logic signed [24:0]    mv_s8;

	always_ff @(posedge clk) begin
		zero_s8 <= (bx_s7 == '0) && (by_s7 == '0);
		if (bx_s7 < 0) begin
			vx_s8 <= -VXW'(bx_s7);
			vy_s8 <= -VXW'(by_s7);
			vz_s8 <= VZW'(Q16_HALF);
		end else begin
			vx_s8 <= VXW'(bx_s7);
			vy_s8 <= VXW'(by_s7);
			vz_s8 <= '0;
		end
		d2_s8 <= d2_s7;
		mv_s8 <= mv_s7;
	end

	// Vectoring chain finds the bearing angle.
	typedef struct packed {
		logic               v;
		logic               zero;
		logic [63:0]        d2;
		logic signed [24:0] mv;
	} vec_side_t;

	vec_side_t vec_side_in, vec_side_out;
	logic signed [VXW-1:0] vec_x [CORDIC_STAGES+1];
	logic signed [VXW-1:0] vec_y [CORDIC_STAGES+1];
	logic signed [VZW-1:0] vec_z [CORDIC_STAGES+1];

	assign vec_side_in = '{v: v_s8, zero: zero_s8, d2: d2_s8, mv: mv_s8};
	assign vec_x[0] = vx_s8;
	assign vec_y[0] = vy_s8;
	assign vec_z[0] = vz_s8;

	sml_delay #(.W($bits(vec_side_t)), .DEPTH(CORDIC_STAGES)) u_vec_side (
		.clk    (clk),
		.arst_n (arst_n),
		.d      (vec_side_in),
		.q      (vec_side_out)
	);

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_vec
		sml_vec_cell #(.SHIFT(k)) u_cell (
			.clk   (clk),
			.x_in  (vec_x[k]),
			.y_in  (vec_y[k]),
			.z_in  (vec_z[k]),
			.x_out (vec_x[k+1]),
			.y_out (vec_y[k+1]),
			.z_out (vec_z[k+1])
		);
	end

	// Stage 9 wraps the bearing to [0,360) degrees; a position at the centre reads 0.
	logic signed [VZW-1:0] z_end, z_wrap;
	logic [24:0]           brg_s9;
	logic [63:0]           d2_s9;
	logic signed [24:0]    mv_s9;

	assign z_end = vec_z[CORDIC_STAGES];

	always_comb begin
		z_wrap = z_end;
		if (z_end < 0) begin
			z_wrap = z_end + VZW'(Q16_FULL);
		end else if (z_end >= VZW'(Q16_FULL)) begin
			z_wrap = z_end - VZW'(Q16_FULL);
		end
	end

	always_ff @(posedge clk) begin
		brg_s9 <= vec_side_out.zero ? '0 : z_wrap[24:0];
		d2_s9  <= vec_side_out.d2;
		mv_s9  <= vec_side_out.mv;
	end

	// Stage 10 turns a true bearing into a magnetic one when the record asks for it.
	logic signed [26:0] mag_diff, mag_wrap;
	logic [24:0]        brg_s10;
	logic [63:0]        d2_s10;

	assign mag_diff = $signed({2'b00, brg_s9}) - 27'(mv_s9);

	always_comb begin
		mag_wrap = mag_diff;
		if (mag_diff < 0) begin
			mag_wrap = mag_diff + 27'(Q16_FULL);
		end else if (mag_diff >= 27'(Q16_FULL)) begin
			mag_wrap = mag_diff - 27'(Q16_FULL);
		end
	end

	always_ff @(posedge clk) begin
		brg_s10 <= magnetic_reference_q ? mag_wrap[24:0] : brg_s9;
		d2_s10  <= d2_s9;
	end

	// Stage 11 picks the sector: greatest start bearing not above the bearing, otherwise
	// the greatest start overall; on equal starts the lower word wins.
	logic [2:0]  cnt_sat;
	logic [1:0]  top_i, pick_i;
	logic        have_top, have_pick;
	logic [8:0]  top_st, pick_st, st;
	logic [26:0] word_s11;
	logic        none_s11;
	logic [63:0] d2_s11;

	assign cnt_sat = (sector_count_q > 3'(MAX_SECTORS)) ? 3'(MAX_SECTORS) : sector_count_q;

	always_comb begin
		top_i     = '0;
		pick_i    = '0;
		have_top  = 1'b0;
		have_pick = 1'b0;
		top_st    = '0;
		pick_st   = '0;
		st        = '0;
		for (int i = 0; i < MAX_SECTORS; i++) begin
			if (3'(i) < cnt_sat) begin
				st = sector_word_q[2'(i)][8:0];
				if (!have_top || st > top_st) begin
					have_top = 1'b1;
					top_st   = st;
					top_i    = 2'(i);
				end
				if ({st, 16'd0} <= brg_s10 && (!have_pick || st > pick_st)) begin
					have_pick = 1'b1;
					pick_st   = st;
					pick_i    = 2'(i);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		word_s11 <= sector_word_q[have_pick ? pick_i : top_i];
		none_s11 <= (cnt_sat == 3'd0);
		d2_s11   <= d2_s10;
	end

	// Stage 12 checks the radius and presents the altitude in feet.
	logic [15:0] rad_sq;
	logic [16:0] alt_ft;
	logic [16:0] minimum_altitude_ft_q;

	assign rad_sq = 16'(word_s11[26:19]) * 16'(word_s11[26:19]);
	assign alt_ft = 17'(word_s11[18:9]) * 17'd100;

	always_ff @(posedge clk) begin
		minimum_altitude_ft_q <= (!none_s11 && d2_s11 <= {rad_sq, 32'd0}) ? alt_ft : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			v_s7   <= 1'b0;
			v_s8   <= 1'b0;
			v_s9   <= 1'b0;
			v_s10  <= 1'b0;
			v_s11  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start && !busy;
			v_s2   <= v_s1;
			v_s3   <= rot_side_out.v;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			v_s6   <= v_s5;
			v_s7   <= v_s6;
			v_s8   <= v_s7;
			v_s9   <= vec_side_out.v;
			v_s10  <= v_s9;
			v_s11  <= v_s10;
			done_q <= v_s11;
		end
	end

	assign done                = done_q;
	assign minimum_altitude_ft = minimum_altitude_ft_q;

`ifndef SYNTHESIS
	// The bearing handed to sector selection is always within one turn.
	a_brg_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s10 |-> brg_s10 < 25'd23592960)
		else $error("bearing outside [0,360) degrees");

	// A position exactly at the centre gives a bearing of zero.
	a_centre_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(vec_side_out.v && vec_side_out.zero) |=> brg_s9 == '0)
		else $error("centre position did not give bearing zero");

	// With no sectors the result is always zero.
	a_no_sectors: assert property (@(posedge clk) disable iff (!arst_n)
		(done && sector_count_q == 3'd0) |-> minimum_altitude_ft == '0)
		else $error("nonzero altitude with no sectors");

	// The largest altitude field times one hundred bounds every result.
	a_alt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> minimum_altitude_ft <= 17'd102300)
		else $error("altitude result out of range");
`endif

endmodule

/* tb/tb_sector_minimum_altitude_lookup_top.sv */
// Self-checking testbench for sector_minimum_altitude_lookup_top: directed and random
// position queries over several configured records, each result checked against a predictor.
// Depends on sml_pkg and the block's RTL.
module tb_sector_minimum_altitude_lookup_top;
	import sml_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Register indexes of the configuration port.
	typedef enum logic [2:0] {
		REG_CENTRE_LAT   = 3'd0,
		REG_CENTRE_LON   = 3'd1,
		REG_MAGNETIC     = 3'd2,
		REG_SECTOR_COUNT = 3'd3,
		REG_SECTOR_0     = 3'd4,
		REG_SECTOR_1     = 3'd5,
		REG_SECTOR_2     = 3'd6,
		REG_SECTOR_3     = 3'd7
	} reg_index_e;

	localparam longint FULL_TURN    = 23592960;
	localparam longint HALF_TURN    = 11796480;
	localparam longint QUARTER_TURN = 5898240;
	localparam longint HALF_Q30_LSB = 64'd536870912;
	localparam int     LATENCY      = 2 * 16 + 12;
	localparam int     STALL_LIMIT  = 2000;

	// Keeps a mirror of the record, predicts the altitude for each query and
	// compares the results that come back in order.
	class altitude_scoreboard;
		logic [26:0]      record [8];
		logic [16:0]      expected_alt [$];
		int               mismatches;
		longint           atan_deg [16] = '{2949120, 1740967, 919879, 466945, 234379,
			117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

		function void write_record(reg_index_e idx, logic [26:0] data);
			record[idx] = data;
		endfunction

		function longint wrap_turn(longint a);
			a = a % FULL_TURN;
			if (a < 0) a += FULL_TURN;
			return a;
		endfunction

		function longint unsigned magnitude(longint v);
			return v < 0 ? -v : v;
		endfunction

		function longint q30_product(longint a, longint b);
			longint unsigned p;
			p = (magnitude(a) * magnitude(b) + HALF_Q30_LSB) >> 30;
			return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
		endfunction

		// Rotation CORDIC: sine and cosine in Q30 of a Q16 degree angle.
		function void sine_cosine(longint a, output longint s, output longint c);
			bit     flip;
			longint x, y, z, nx, ny;
			flip = 0;
			x = CORDIC_GAIN_Q30;
			y = 0;
			a = a % FULL_TURN;
			if (a > HALF_TURN) a -= FULL_TURN;
			if (a <= -HALF_TURN) a += FULL_TURN;
			if (a > QUARTER_TURN) begin
				a -= HALF_TURN;
				flip = 1;
			end else if (a < -QUARTER_TURN) begin
				a += HALF_TURN;
				flip = 1;
			end
			z = a;
			for (int i = 0; i < 16; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i);
					ny = y + (x >>> i);
					z -= atan_deg[i];
				end else begin
					nx = x + (y >>> i);
					ny = y - (x >>> i);
					z += atan_deg[i];
				end
				x = nx;
				y = ny;
			end
			s = flip ? -y : y;
			c = flip ? -x : x;
		endfunction

		// Vectoring CORDIC: angle of (x,y) in [0,360) degrees, Q16.
		function longint vector_angle(longint x, longint y);
			longint z, nx, ny;
			z = 0;
			if (x == 0 && y == 0) return 0;
			if (x < 0) begin
				x = -x;
				y = -y;
				z = HALF_TURN;
			end
			for (int i = 0; i < 16; i++) begin
				if (y >= 0) begin
					nx = x + (y >>> i);
					ny = y - (x >>> i);
					z += atan_deg[i];
				end else begin
					nx = x - (y >>> i);
					ny = y + (x >>> i);
					z -= atan_deg[i];
				end
				x = nx;
				y = ny;
			end
			return wrap_turn(z);
		endfunction

		function logic [16:0] sector_altitude(longint lat, longint lon, longint var_deg);
			longint          la1, lo1, s1, c1, s2, c2, sd, cd, sm, cm, bx, by, brg, st;
			longint          pick_start, top_start;
			longint unsigned dlat, dlon, d2, r;
			int              count, pick, top;
			logic [26:0]     word;
			la1 = longint'($signed(record[REG_CENTRE_LAT][23:0]));
			lo1 = longint'($signed(record[REG_CENTRE_LON][24:0]));
			count = record[REG_SECTOR_COUNT][2:0];
			if (count > 4) count = 4;
			if (count == 0) return '0;
			sine_cosine((la1 + lat) / 2, sm, cm);
			dlat = magnitude(lat - la1) * 60;
			dlon = (magnitude(lon - lo1) * 60 * magnitude(cm) + HALF_Q30_LSB) >> 30;
			d2 = dlat * dlat + dlon * dlon;
			sine_cosine(la1, s1, c1);
			sine_cosine(lat, s2, c2);
			sine_cosine(lon - lo1, sd, cd);
			by = q30_product(sd, c2);
			bx = q30_product(c1, s2) - q30_product(q30_product(s1, c2), cd);
			brg = vector_angle(bx, by);
			if (record[REG_MAGNETIC][0]) brg = wrap_turn(brg - var_deg);
			pick = -1;
			top = -1;
			pick_start = -1;
			top_start = -1;
			for (int i = 0; i < count; i++) begin
				st = record[REG_SECTOR_0 + i][8:0];
				if (st > top_start) begin
					top_start = st;
					top = i;
				end
				if ((st << 16) <= brg && st > pick_start) begin
					pick_start = st;
					pick = i;
				end
			end
			if (pick < 0) pick = top;
			word = record[REG_SECTOR_0 + pick];
			r = longint'(word[26:19]) << 16;
			if (d2 <= r * r) return 17'(word[18:9] * 100);
			return '0;
		endfunction

		function void note_query(logic signed [23:0] lat, logic signed [24:0] lon,
				logic signed [24:0] var_deg);
			expected_alt = {expected_alt, sector_altitude(lat, lon, var_deg)};
		endfunction

		function void check_result(logic [16:0] actual);
			logic [16:0] want;
			if (expected_alt.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: minimum_altitude_ft=%0d", actual);
				return;
			end
			want = expected_alt.pop_front();
			if (actual !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Mismatch: minimum_altitude_ft expected %0d, got %0d", want, actual);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [23:0] aircraft_latitude;
	logic signed [24:0] aircraft_longitude;
	logic signed [24:0] magnetic_variation;
	logic               done;
	logic [16:0]        minimum_altitude_ft;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [26:0]        cfg_wdata;

	altitude_scoreboard board = new();
	bit                 gaps_enabled = 1;
	int                 quiet_cycles = 0;

	sector_minimum_altitude_lookup_top i_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.start               (start),
		.busy                (busy),
		.aircraft_latitude   (aircraft_latitude),
		.aircraft_longitude  (aircraft_longitude),
		.magnetic_variation  (magnetic_variation),
		.done                (done),
		.minimum_altitude_ft (minimum_altitude_ft),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_wdata           (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Both monitors sample at the rising edge; inputs only move at the falling edge,
	// so the values seen here are the ones the block takes at this edge.
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			board.note_query(aircraft_latitude, aircraft_longitude, magnetic_variation);
		if (arst_n && done)
			board.check_result(minimum_altitude_ft);
	end

	// Watchdog: a run that stops moving items in either direction is a failure.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL sector_minimum_altitude_lookup_top");
			$finish;
		end
	end

	// Writes one register; entered and left at a falling edge.
	task automatic write_reg(reg_index_e idx, logic [26:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		board.write_record(idx, data);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Offers one query and holds it until the block takes it. Random gaps in front of some
	// items keep start low for about a third of the time.
	task automatic send_query(logic signed [23:0] lat, logic signed [24:0] lon,
			logic signed [24:0] var_deg);
		if (gaps_enabled && $urandom_range(99) < 26) begin
			start = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		start = 1'b1;
		aircraft_latitude = lat;
		aircraft_longitude = lon;
		magnetic_variation = var_deg;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// Lets the pipeline empty so that the record can be rewritten safely.
	task automatic drain_pipeline();
		start = 1'b0;
		while (board.expected_alt.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	// Packs one sector word: start bearing, altitude in hundreds of feet, radius.
	function automatic logic [26:0] sector_word(int bearing, int alt, int radius);
		return {8'(radius), 10'(alt), 9'(bearing)};
	endfunction

	// Loads a full record. Phase picks the corner it stresses.
	task automatic load_record(int phase);
		logic signed [23:0] lat;
		logic signed [24:0] lon;
		int                 count;
		lat = 24'($urandom_range(0, 2 * 5898240) - 5898240);
		lon = 25'($urandom_range(0, 2 * 11796480) - 11796480);
		if (phase == 2) begin
			lat = 24'(5898240);
			lon = 25'(11796480);
		end else if (phase == 3) begin
			lat = 24'(-5898240);
			lon = 25'(-11796480);
		end else if (phase == 5) begin
			lat = 24'($urandom);
			lon = 25'($urandom);
		end
		count = (phase == 4) ? 0 : (phase == 5) ? $urandom_range(5, 7) : $urandom_range(1, 4);
		if (phase == 1) count = 4;
		write_reg(REG_CENTRE_LAT, 27'(lat));
		write_reg(REG_CENTRE_LON, 27'(lon));
		write_reg(REG_MAGNETIC, 27'(phase % 2));
		write_reg(REG_SECTOR_COUNT, 27'(count));
		for (int i = 0; i < 4; i++) begin
			if (phase == 1) begin
				// Quadrant sectors with the widest radius.
				write_reg(reg_index_e'(REG_SECTOR_0 + i), sector_word(90 * i, 20 + i, 255));
			end else if (phase == 2) begin
				// Equal start bearings, zero radius and oversized altitudes.
				write_reg(reg_index_e'(REG_SECTOR_0 + i), sector_word(180, 1023 - i, i == 0 ? 0 : 255));
			end else if (phase == 3) begin
				// Start bearings above 359 reachable only by wrapping.
				write_reg(reg_index_e'(REG_SECTOR_0 + i), sector_word(i < 2 ? 360 + 70 * i : 45 * i,
					$urandom_range(0, 1023), $urandom_range(100, 255)));
			end else begin
				write_reg(reg_index_e'(REG_SECTOR_0 + i), 27'($urandom));
			end
		end
	endtask

	// Mostly positions close to the centre so that radii are hit, the rest anywhere.
	task automatic random_query();
		logic signed [23:0] lat;
		logic signed [24:0] lon;
		logic signed [24:0] var_deg;
		int                 reach;
		reach = $urandom_range(0, 3) == 0 ? 65536 : 327680;
		if ($urandom_range(99) < 80) begin
			lat = 24'(int'($signed(board.record[REG_CENTRE_LAT][23:0]))
				+ int'($urandom_range(0, 2 * reach)) - reach);
			lon = 25'(int'($signed(board.record[REG_CENTRE_LON][24:0]))
				+ int'($urandom_range(0, 2 * reach)) - reach);
		end else begin
			lat = 24'($urandom);
			lon = 25'($urandom);
		end
		var_deg = $urandom_range(1) ? 25'($urandom)
			: 25'($urandom_range(0, 2 * 11796480) - 11796480);
		send_query(lat, lon, var_deg);
	endtask

	initial begin
		logic signed [23:0] clat;
		logic signed [24:0] clon;
		arst_n = 1'b0;
		start = 1'b0;
		aircraft_latitude = '0;
		aircraft_longitude = '0;
		magnetic_variation = '0;
		cfg_we = 1'b0;
		cfg_index = REG_CENTRE_LAT;
		cfg_wdata = '0;
		for (int i = 0; i < 8; i++) board.write_record(reg_index_e'(i), '0);
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// A few queries against the reset record, which has no sectors.
		send_query(24'sd0, 25'sd0, 25'sd0);
		send_query(24'sd300000, -25'sd200000, 25'sd1000);
		drain_pipeline();

		// Directed part against quadrant sectors around a random centre.
		load_record(1);
		clat = $signed(board.record[REG_CENTRE_LAT][23:0]);
		clon = $signed(board.record[REG_CENTRE_LON][24:0]);
		send_query(clat, clon, 25'sd0);                 // aircraft at the centre
		send_query(clat, clon, 25'sd11796480);
		send_query(clat + 24'sd65536, clon, 25'sd0);     // north
		send_query(clat - 24'sd65536, clon, 25'sd0);     // south
		send_query(clat, clon + 25'sd65536, 25'sd0);     // east
		send_query(clat, clon - 25'sd65536, 25'sd0);     // west
		send_query(clat + 24'sd65536, clon, -25'sd11796480);
		send_query(clat + 24'sd65536, clon, 25'sd5898240);
		send_query(24'sd5898240, 25'sd11796480, 25'sd11796480);
		send_query(-24'sd5898240, -25'sd11796480, -25'sd11796480);
		send_query(24'sh7FFFFF, 25'sh0FFFFFF, 25'sh0FFFFFF);
		send_query(24'sh800000, 25'sh1000000, 25'sh1000000);
		send_query(24'sd0, 25'sh0FFFFFF, 25'sd0);
		send_query(24'sh800000, 25'sd0, 25'sh1000000);
		send_query(clat + 24'sd300000, clon + 25'sd300000, 25'sd0);
		send_query(clat - 24'sd1000000, clon + 25'sd5000, 25'sd0);
		for (int i = 0; i < 40; i++) random_query();
		drain_pipeline();

		// Random part over records that stress different corners.
		for (int phase = 2; phase <= 7; phase++) begin
			load_record(phase > 5 ? 0 : phase);
			gaps_enabled = (phase != 6);
			for (int i = 0; i < 85; i++) random_query();
			drain_pipeline();
		end

		start = 1'b0;
		while (board.expected_alt.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		if (board.mismatches == 0) begin
			$display("PASS sector_minimum_altitude_lookup_top");
		end else begin
			$display("FAIL sector_minimum_altitude_lookup_top");
		end
		$finish;
	end

endmodule
